>>> design/anxb_pkg.sv
// Shared types and constants for the Annex B NAL deframer.
// Used by anxb_window and annexb_nal_deframer_unit; depends on nothing.
`default_nettype none

package anxb_pkg;

    localparam int BYTE_W   = 8;
    localparam int OFFSET_W = 32;
    localparam int FIELDS_W = 49;
    localparam int TDATA_W  = 56;
    localparam int PAD_W    = TDATA_W - FIELDS_W;

    localparam logic KIND_HEADER  = 1'b0;
    localparam logic KIND_PAYLOAD = 1'b1;

    localparam logic [1:0] ERR_OK        = 2'd0;
    localparam logic [1:0] ERR_EMPTY     = 2'd1;
    localparam logic [1:0] ERR_FORBIDDEN = 2'd2;

    localparam logic [BYTE_W-1:0] ZERO_BYTE  = 8'h00;
    localparam logic [BYTE_W-1:0] MARKER_END = 8'h01;

    typedef struct packed {
        logic                item_kind;
        logic [BYTE_W-1:0]   payload_byte;
        logic [1:0]          ref_priority;
        logic [4:0]          unit_type;
        logic [1:0]          packet_error;
        logic [OFFSET_W-1:0] packet_offset;
        logic                last_of_packet;
    } result_t;

    typedef struct packed {
        logic    valid;
        result_t res;
    } core_out_t;

endpackage

`default_nettype wire

>>> design/annexb_nal_deframer_unit.sv
// Top level of the Annex B NAL deframer: stream ports and result register.
// Depends on anxb_pkg and anxb_window.
//
// Usage:
//   s_ channel carries one raw byte-stream byte per beat in s_tdata[7:0].
//   m_ channel carries one result per beat: a packet header (m_tuser 0)
//   or a payload byte (m_tuser 1); m_tlast marks the final item of a packet.
//   Start-code bytes (00 00 01) never appear on the output, and bytes before
//   the first start code are dropped. Each byte is held in the three-byte
//   window, so a packet's bytes come out as later input bytes arrive; the
//   final bytes of a packet with no closing start code stay held.
//   A result is registered and leaves on m_ in the cycle after the input
//   beat that releases it. Throughput: one byte per cycle while m_tready
//   is high, set by the single result register; s_tready is high whenever
//   that register is empty or being drained in the same cycle.
//   Reset (aresetn low, synchronous) clears window count, packet state,
//   stream offset and result valid flag, not window or result data. While
//   m_tready is low and a result is waiting, s_tready drops and the result holds.
`default_nettype none

module annexb_nal_deframer_unit (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output      logic                          s_tready,
    input  wire logic [7:0]                    s_tdata,  // [7:0] stream_byte
    output      logic                          m_tvalid,
    input  wire logic                          m_tready,
    // [7:0] payload_byte, [9:8] ref_priority, [14:10] unit_type,
    // [16:15] packet_error, [48:17] packet_offset, [55:49] zero
    output      logic [anxb_pkg::TDATA_W-1:0]  m_tdata,
    output      logic                          m_tuser,  // [0] item_kind
    output      logic                          m_tlast   // last_of_packet
);

    logic                 beat_accept;
    anxb_pkg::core_out_t  core_out;
    logic                 out_valid_reg;
    anxb_pkg::result_t    out_res_reg;

    assign s_tready    = !out_valid_reg || m_tready;
    assign beat_accept = s_tvalid && s_tready;

    anxb_window u_window (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .beat_accept (beat_accept),
        .beat_byte   (s_tdata),
        .core_out    (core_out)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (s_tready) begin
            out_valid_reg <= core_out.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && core_out.valid) begin
            out_res_reg <= core_out.res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_res_reg.item_kind;
    assign m_tlast  = out_res_reg.last_of_packet;
    assign m_tdata  = {{anxb_pkg::PAD_W{1'b0}},
                       out_res_reg.packet_offset,
                       out_res_reg.packet_error,
                       out_res_reg.unit_type,
                       out_res_reg.ref_priority,
                       out_res_reg.payload_byte};

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty result register");

    a_result_registered: assert property (@(posedge aclk) disable iff (!aresetn)
        (beat_accept && core_out.valid) |=> m_tvalid)
        else $error("released result not presented");

    a_empty_is_last_header: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tdata[16:15] == anxb_pkg::ERR_EMPTY)) |->
            (m_tlast && (m_tuser == anxb_pkg::KIND_HEADER)))
        else $error("empty packet result not a final header");

    a_payload_no_header: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser == anxb_pkg::KIND_PAYLOAD)) |-> (m_tdata[48:8] == '0))
        else $error("payload result carries header fields");

endmodule

`default_nettype wire

>>> design/anxb_window.sv
// Hold window, start-code match and header/payload decode for one byte beat.
// Depends on anxb_pkg.
`default_nettype none

module anxb_window (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        beat_accept,
    input  wire logic [anxb_pkg::BYTE_W-1:0] beat_byte,
    output anxb_pkg::core_out_t              core_out
);

    logic [anxb_pkg::BYTE_W-1:0]   win_reg   [3];
    logic [anxb_pkg::BYTE_W-1:0]   win_next  [3];
    logic [1:0]                    count_reg, count_next;
    logic                          inside_reg, inside_next;
    logic                          sent_reg, sent_next;
    logic [anxb_pkg::OFFSET_W-1:0] pos_reg;

    logic                          match;
    logic                          emit;
    logic                          empty_pkt;
    logic                          last;
    logic [anxb_pkg::BYTE_W-1:0]   head;

    always_comb begin
        unique case (count_reg)
            2'd2:    match = (win_reg[0] == anxb_pkg::ZERO_BYTE) &&
                             (win_reg[1] == anxb_pkg::ZERO_BYTE) &&
                             (beat_byte == anxb_pkg::MARKER_END);
            2'd3:    match = (win_reg[1] == anxb_pkg::ZERO_BYTE) &&
                             (win_reg[2] == anxb_pkg::ZERO_BYTE) &&
                             (beat_byte == anxb_pkg::MARKER_END);
            default: match = 1'b0;
        endcase
    end

    assign head      = win_reg[0];
    assign emit      = inside_reg && (count_reg == 2'd3);
    assign empty_pkt = inside_reg && match && (count_reg != 2'd3) && !sent_reg;
    assign last      = match;

    always_comb begin
        core_out.valid = beat_accept && (emit || empty_pkt);
        core_out.res   = '0;
        core_out.res.last_of_packet = last;
        if (empty_pkt) begin
            core_out.res.item_kind     = anxb_pkg::KIND_HEADER;
            core_out.res.packet_error  = anxb_pkg::ERR_EMPTY;
            core_out.res.packet_offset = pos_reg - 32'd2;
        end else if (!sent_reg) begin
            core_out.res.item_kind     = anxb_pkg::KIND_HEADER;
            core_out.res.ref_priority  = head[6:5];
            core_out.res.unit_type     = head[4:0];
            core_out.res.packet_error  = head[7] ? anxb_pkg::ERR_FORBIDDEN : anxb_pkg::ERR_OK;
            core_out.res.packet_offset = pos_reg - 32'd3;
        end else begin
            core_out.res.item_kind    = anxb_pkg::KIND_PAYLOAD;
            core_out.res.payload_byte = head;
        end
    end

    always_comb begin
        win_next    = win_reg;
        count_next  = count_reg;
        inside_next = inside_reg;
        sent_next   = sent_reg;
        if (match) begin
            inside_next = 1'b1;
            sent_next   = 1'b0;
            count_next  = 2'd0;
        end else if (count_reg == 2'd3) begin
            win_next[0] = win_reg[1];
            win_next[1] = win_reg[2];
            win_next[2] = beat_byte;
            if (emit) begin
                sent_next = 1'b1;
            end
        end else begin
            win_next[count_reg] = beat_byte;
            count_next          = count_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (beat_accept) begin
            win_reg <= win_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= 2'd0;
            inside_reg <= 1'b0;
            sent_reg   <= 1'b0;
            pos_reg    <= '0;
        end else if (beat_accept) begin
            count_reg  <= count_next;
            inside_reg <= inside_next;
            sent_reg   <= sent_next;
            pos_reg    <= pos_reg + 32'd1;
        end
    end

endmodule

`default_nettype wire
